// ===== rtl/cfr_pkg.sv =====
// ----------------------------------------------------------------------------
// cfr_pkg
// Shared types and constants of the checksummed frame receiver.
// ----------------------------------------------------------------------------
package cfr_pkg;

  localparam logic [7:0] HDR0    = 8'hA8;
  localparam logic [7:0] HDR1    = 8'h8A;
  localparam logic [7:0] TRAILER = 8'hED;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_H0_RD,
    ST_H0_WT,
    ST_H1_WT,
    ST_LEN_CHK,
    ST_LEN_WT,
    ST_LEN_CMP,
    ST_TRL_WT,
    ST_SUM_RD,
    ST_SUM_WT,
    ST_CHK_WT,
    ST_CMD_WT,
    ST_DONE
  } cfr_state_t;

  // byte offset from the buffer head that the read port addresses
  typedef enum logic [2:0] {
    OFF_0,
    OFF_1,
    OFF_2,
    OFF_3,
    OFF_SUM_IDX,
    OFF_LEN_P2,
    OFF_LEN_P3
  } cfr_off_t;

  typedef struct packed {
    logic     accept;
    cfr_off_t rd_sel;
    logic     drop1;
    logic     drop2;
    logic     ld_len;
    logic     sum_clr;
    logic     sum_add;
    logic     ld_cmd;
    logic     out_load;
  } cfr_cmd_t;

  typedef struct packed {
    logic cnt_le1;
    logic cnt_lt6;
    logic cnt_lt_len4;
    logic rd_is_hdr0;
    logic rd_is_hdr1;
    logic rd_is_trl;
    logic sum_match;
    logic idx_done;
    logic out_free;
  } cfr_stat_t;

endpackage

// ===== rtl/cfr_ctrl.sv =====
// ----------------------------------------------------------------------------
// cfr_ctrl
// Sequencer: header scan, length and trailer check, checksum walk, result.
// ----------------------------------------------------------------------------
module cfr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_clear,
  output logic              in_tready,
  input  cfr_pkg::cfr_stat_t stat,
  output cfr_pkg::cfr_cmd_t  cmd
);

  cfr_pkg::cfr_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cfr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cfr_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = in_clear ? cfr_pkg::ST_DONE : cfr_pkg::ST_H0_RD;
        end
      end
      cfr_pkg::ST_H0_RD: begin
        state_nxt = stat.cnt_le1 ? cfr_pkg::ST_LEN_CHK : cfr_pkg::ST_H0_WT;
      end
      cfr_pkg::ST_H0_WT: begin
        state_nxt = stat.rd_is_hdr0 ? cfr_pkg::ST_H1_WT : cfr_pkg::ST_H0_RD;
      end
      cfr_pkg::ST_H1_WT: begin
        state_nxt = stat.rd_is_hdr1 ? cfr_pkg::ST_LEN_CHK : cfr_pkg::ST_H0_RD;
      end
      cfr_pkg::ST_LEN_CHK: begin
        state_nxt = stat.cnt_lt6 ? cfr_pkg::ST_DONE : cfr_pkg::ST_LEN_WT;
      end
      cfr_pkg::ST_LEN_WT: begin
        state_nxt = cfr_pkg::ST_LEN_CMP;
      end
      cfr_pkg::ST_LEN_CMP: begin
        state_nxt = stat.cnt_lt_len4 ? cfr_pkg::ST_DONE : cfr_pkg::ST_TRL_WT;
      end
      cfr_pkg::ST_TRL_WT: begin
        state_nxt = stat.rd_is_trl ? cfr_pkg::ST_SUM_RD : cfr_pkg::ST_DONE;
      end
      cfr_pkg::ST_SUM_RD: begin
        state_nxt = stat.idx_done ? cfr_pkg::ST_CHK_WT : cfr_pkg::ST_SUM_WT;
      end
      cfr_pkg::ST_SUM_WT: begin
        state_nxt = cfr_pkg::ST_SUM_RD;
      end
      cfr_pkg::ST_CHK_WT: begin
        state_nxt = stat.sum_match ? cfr_pkg::ST_CMD_WT : cfr_pkg::ST_DONE;
      end
      cfr_pkg::ST_CMD_WT: begin
        state_nxt = cfr_pkg::ST_DONE;
      end
      cfr_pkg::ST_DONE: begin
        if (stat.out_free) begin
          state_nxt = cfr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = cfr_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_tready    = 1'b0;
    cmd          = '0;
    cmd.rd_sel   = cfr_pkg::OFF_0;
    unique case (state_r)
      cfr_pkg::ST_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
      end
      cfr_pkg::ST_H0_RD: begin
        cmd.rd_sel = cfr_pkg::OFF_0;
      end
      cfr_pkg::ST_H0_WT: begin
        cmd.rd_sel = cfr_pkg::OFF_1;
        cmd.drop1  = !stat.rd_is_hdr0;
      end
      cfr_pkg::ST_H1_WT: begin
        cmd.drop1 = !stat.rd_is_hdr1;
      end
      cfr_pkg::ST_LEN_CHK: begin
        cmd.rd_sel = cfr_pkg::OFF_2;
      end
      cfr_pkg::ST_LEN_WT: begin
        cmd.ld_len = 1'b1;
      end
      cfr_pkg::ST_LEN_CMP: begin
        cmd.rd_sel = cfr_pkg::OFF_LEN_P3;
      end
      cfr_pkg::ST_TRL_WT: begin
        cmd.sum_clr = 1'b1;
        cmd.drop2   = !stat.rd_is_trl;
      end
      cfr_pkg::ST_SUM_RD: begin
        cmd.rd_sel = stat.idx_done ? cfr_pkg::OFF_LEN_P2 : cfr_pkg::OFF_SUM_IDX;
      end
      cfr_pkg::ST_SUM_WT: begin
        cmd.sum_add = 1'b1;
      end
      cfr_pkg::ST_CHK_WT: begin
        cmd.rd_sel = cfr_pkg::OFF_3;
        cmd.drop2  = !stat.sum_match;
      end
      cfr_pkg::ST_CMD_WT: begin
        cmd.ld_cmd = 1'b1;
      end
      cfr_pkg::ST_DONE: begin
        cmd.out_load = stat.out_free;
      end
      default: begin
        cmd.rd_sel = cfr_pkg::OFF_0;
      end
    endcase
  end

endmodule

// ===== rtl/cfr_dpath.sv =====
// ----------------------------------------------------------------------------
// cfr_dpath
// Circular byte buffer, head and fill count, length, checksum and result
// register.
// ----------------------------------------------------------------------------
module cfr_dpath #(
  parameter int DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_clear,
  input  logic [7:0]        in_byte,
  input  cfr_pkg::cfr_cmd_t  cmd,
  output cfr_pkg::cfr_stat_t stat,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [31:0]       out_data
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CW    = (CNT_W > 9) ? CNT_W : 9;

  logic [7:0]       mem [DEPTH];
  logic [7:0]       rd_data_r;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       len_r;
  logic [7:0]       sum_r;
  logic [7:0]       idx_r;
  logic [7:0]       rcmd_r;
  logic             ok_r;
  logic             ovf_r;

  logic             out_valid_r;
  logic             out_cmpl_r;
  logic [8:0]       out_len_r;
  logic [7:0]       out_rcmd_r;
  logic [6:0]       out_held_r;
  logic             out_ovf_r;

  logic             full;
  logic             wr_en;
  logic [8:0]       off;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;

  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W:0] s);
    logic [IDX_W:0] w;
    w = (s >= (IDX_W+1)'(DEPTH)) ? s - (IDX_W+1)'(DEPTH) : s;
    return w[IDX_W-1:0];
  endfunction

  assign full  = (cnt_r >= CNT_W'(DEPTH));
  assign wr_en = cmd.accept && !in_clear && !full;

  always_comb begin
    case (cmd.rd_sel)
      cfr_pkg::OFF_0:       off = 9'd0;
      cfr_pkg::OFF_1:       off = 9'd1;
      cfr_pkg::OFF_2:       off = 9'd2;
      cfr_pkg::OFF_3:       off = 9'd3;
      cfr_pkg::OFF_SUM_IDX: off = {1'b0, idx_r} + 9'd2;
      cfr_pkg::OFF_LEN_P2:  off = {1'b0, len_r} + 9'd2;
      cfr_pkg::OFF_LEN_P3:  off = {1'b0, len_r} + 9'd3;
      default:              off = 9'd0;
    endcase
  end

  assign rd_addr = wrap_add({1'b0, head_r} + (IDX_W+1)'(off));
  assign wr_addr = wrap_add({1'b0, head_r} + (IDX_W+1)'(cnt_r));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_byte;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    head_nxt = head_r;
    cnt_nxt  = cnt_r;
    if (cmd.accept && in_clear) begin
      head_nxt = '0;
      cnt_nxt  = '0;
    end else if (wr_en) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (cmd.drop1) begin
      head_nxt = wrap_add({1'b0, head_r} + (IDX_W+1)'(1));
      cnt_nxt  = cnt_r - CNT_W'(1);
    end else if (cmd.drop2) begin
      head_nxt = wrap_add({1'b0, head_r} + (IDX_W+1)'(2));
      cnt_nxt  = cnt_r - CNT_W'(2);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      cnt_r       <= '0;
      ok_r        <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      head_r <= head_nxt;
      cnt_r  <= cnt_nxt;
      if (cmd.accept) begin
        ok_r  <= 1'b0;
        ovf_r <= !in_clear && full;
      end else if (cmd.ld_cmd) begin
        ok_r <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_len) begin
      len_r <= rd_data_r;
    end
    if (cmd.sum_clr) begin
      sum_r <= '0;
      idx_r <= '0;
    end else if (cmd.sum_add) begin
      sum_r <= sum_r + rd_data_r;
      idx_r <= idx_r + 8'd1;
    end
    if (cmd.ld_cmd) begin
      rcmd_r <= rd_data_r;
    end
    if (cmd.out_load) begin
      out_cmpl_r <= ok_r;
      out_len_r  <= ok_r ? ({1'b0, len_r} + 9'd4) : '0;
      out_rcmd_r <= ok_r ? rcmd_r : '0;
      out_held_r <= 7'(cnt_r);
      out_ovf_r  <= ovf_r;
    end
  end

  always_comb begin
    stat.cnt_le1     = (cnt_r <= CNT_W'(1));
    stat.cnt_lt6     = (cnt_r < CNT_W'(6));
    stat.cnt_lt_len4 = (CW'(cnt_r) < (CW'(len_r) + CW'(4)));
    stat.rd_is_hdr0  = (rd_data_r == cfr_pkg::HDR0);
    stat.rd_is_hdr1  = (rd_data_r == cfr_pkg::HDR1);
    stat.rd_is_trl   = (rd_data_r == cfr_pkg::TRAILER);
    stat.sum_match   = (sum_r == rd_data_r);
    stat.idx_done    = (idx_r == len_r);
    stat.out_free    = !out_valid_r || out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_data  = {6'd0, out_ovf_r, out_held_r, out_rcmd_r, out_len_r, out_cmpl_r};

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("fill count above buffer depth");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result loaded over an untaken result");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept && in_clear |=> cnt_r == '0)
    else $error("clear did not empty the buffer");

  a_drop2: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.drop2 |-> cnt_r >= CNT_W'(6))
    else $error("header drop with too few bytes held");

endmodule

// ===== rtl/checksummed_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// checksummed_frame_receiver
// Collects received bytes and reports after each one whether the buffer head
// holds a complete A8 8A L .. S ED frame with a good checksum.
//
// Input channel: one transfer per received byte (in_tuser = 0) or per buffer
// clear (in_tuser = 1). Result channel: one transfer per input transfer with
// the frame status, its length and command byte, the bytes held and an
// overflow flag for a byte dropped on a full buffer.
// Each item is processed alone by a sequencer over a buffer memory with a
// write port and a registered read port; in_tready is high only between
// items. A clear goes straight to the result. A byte is stored if there is
// room, then the header scan drops bytes from the head until A8 8A leads it
// or at most one byte is left, then the length, trailer and checksum are
// checked and, for a complete frame, the command byte is loaded. out_tvalid
// rises as the sequencer returns to idle.
// The result register holds a finished result while out_tready is low; the
// next item is then accepted and runs, and waits to load its result.
// Reset empties the buffer (head and fill count to zero) and clears the
// result valid; buffer contents are not cleared.
// ----------------------------------------------------------------------------
module checksummed_frame_receiver #(
  parameter int BUFFER_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // [0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [0] frame_complete, [9:1] frame_length,
                                  // [17:10] reply_command, [24:18] bytes_held,
                                  // [25] overflow, [31:26] zero
);

  cfr_pkg::cfr_cmd_t  cmd;
  cfr_pkg::cfr_stat_t stat;

  cfr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_clear  (in_tuser),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  cfr_dpath #(
    .DEPTH (BUFFER_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_clear  (in_tuser),
    .in_byte   (in_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule
